// ===== rtl/core/arscm_pkg.sv =====
// ----------------------------------------------------------------------------
// arscm_pkg
// Shared types and constants for the alternating row sorter with column
// maxima.
// ----------------------------------------------------------------------------
package arscm_pkg;

  localparam int unsigned RowLen            = 4;
  localparam int unsigned FieldWidth        = 16;
  localparam int unsigned DefaultValueWidth = 16;
  // Output queue depth; a last row needs two free slots.
  localparam int unsigned OutDepth          = 4;

  typedef enum logic {
    KIND_ROW = 1'b0,
    KIND_MAX = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e                                kind;
    logic [RowLen-1:0][FieldWidth-1:0]    vals;
    logic                                 run_end;
  } result_t;

  typedef struct packed {
    logic row_en;
    logic max_en;
  } push_t;

endpackage

// ===== rtl/core/arscm_sort.sv =====
// ----------------------------------------------------------------------------
// arscm_sort
// Five-comparator sorting network over one row of four values, with the
// order reversed for descending rows.
// ----------------------------------------------------------------------------
module arscm_sort #(
  parameter int unsigned VALUE_WIDTH = arscm_pkg::DefaultValueWidth
) (
  input  logic signed [VALUE_WIDTH-1:0] row_i    [arscm_pkg::RowLen],
  input  logic                          desc_i,
  output logic signed [VALUE_WIDTH-1:0] sorted_o [arscm_pkg::RowLen]
);

  logic signed [VALUE_WIDTH-1:0] l1 [arscm_pkg::RowLen];
  logic signed [VALUE_WIDTH-1:0] l2 [arscm_pkg::RowLen];
  logic signed [VALUE_WIDTH-1:0] l3 [arscm_pkg::RowLen];

  always_comb begin
    // First layer: pairs (0,1) and (2,3).
    l1[0] = (row_i[0] > row_i[1]) ? row_i[1] : row_i[0];
    l1[1] = (row_i[0] > row_i[1]) ? row_i[0] : row_i[1];
    l1[2] = (row_i[2] > row_i[3]) ? row_i[3] : row_i[2];
    l1[3] = (row_i[2] > row_i[3]) ? row_i[2] : row_i[3];
    // Second layer: minima and maxima of the pairs.
    l2[0] = (l1[0] > l1[2]) ? l1[2] : l1[0];
    l2[2] = (l1[0] > l1[2]) ? l1[0] : l1[2];
    l2[1] = (l1[1] > l1[3]) ? l1[3] : l1[1];
    l2[3] = (l1[1] > l1[3]) ? l1[1] : l1[3];
    // Third layer: the two middle values.
    l3[0] = l2[0];
    l3[3] = l2[3];
    l3[1] = (l2[1] > l2[2]) ? l2[2] : l2[1];
    l3[2] = (l2[1] > l2[2]) ? l2[1] : l2[2];
    for (int j = 0; j < arscm_pkg::RowLen; j++) begin
      sorted_o[j] = desc_i ? l3[arscm_pkg::RowLen-1-j] : l3[j];
    end
  end

endmodule

// ===== rtl/core/arscm_colmax.sv =====
// ----------------------------------------------------------------------------
// arscm_colmax
// Running maximum of each column over the sorted rows of one run.
// ----------------------------------------------------------------------------
module arscm_colmax #(
  parameter int unsigned VALUE_WIDTH = arscm_pkg::DefaultValueWidth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          upd_i,
  input  logic                          last_i,
  input  logic signed [VALUE_WIDTH-1:0] row_i  [arscm_pkg::RowLen],
  output logic signed [VALUE_WIDTH-1:0] max_o  [arscm_pkg::RowLen]
);

  logic signed [VALUE_WIDTH-1:0] max_q [arscm_pkg::RowLen];
  logic signed [VALUE_WIDTH-1:0] max_d [arscm_pkg::RowLen];
  logic                          first_q, first_d;

  always_comb begin
    // The first row of a run loads the maxima outright.
    for (int j = 0; j < arscm_pkg::RowLen; j++) begin
      max_o[j] = (first_q || (row_i[j] > max_q[j])) ? row_i[j] : max_q[j];
      max_d[j] = max_q[j];
      if (upd_i) begin
        max_d[j] = last_i ? '0 : max_o[j];
      end
    end
    first_d = first_q;
    if (upd_i) begin
      first_d = last_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= 1'b1;
      for (int j = 0; j < arscm_pkg::RowLen; j++) begin
        max_q[j] <= '0;
      end
    end else begin
      first_q <= first_d;
      max_q   <= max_d;
    end
  end

endmodule

// ===== rtl/core/arscm_outq.sv =====
// ----------------------------------------------------------------------------
// arscm_outq
// Small result queue that takes one or two results a cycle and hands one
// out at a time.
// ----------------------------------------------------------------------------
module arscm_outq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  arscm_pkg::push_t    push_i,
  input  arscm_pkg::result_t  row_res_i,
  input  arscm_pkg::result_t  max_res_i,
  output logic                room2_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output arscm_pkg::result_t  head_o
);

  localparam int unsigned PtrW = $clog2(arscm_pkg::OutDepth);
  localparam int unsigned CntW = $clog2(arscm_pkg::OutDepth + 1);

  arscm_pkg::result_t ent_q [arscm_pkg::OutDepth];
  logic [PtrW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               pop;
  logic [PtrW-1:0]    wr_nxt;

  assign out_valid_o = (cnt_q != '0);
  assign head_o      = ent_q[rd_q];
  assign pop         = out_valid_o && !out_stall_i;
  // Two free slots are required so that a last row never overflows.
  assign room2_o     = (cnt_q <= CntW'(arscm_pkg::OutDepth - 2));
  assign wr_nxt      = wr_q + PtrW'(1);

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i.row_en && push_i.max_en) begin
      wr_d = wr_q + PtrW'(2);
    end else if (push_i.row_en) begin
      wr_d = wr_nxt;
    end
    if (pop) begin
      rd_d = rd_q + PtrW'(1);
    end
    cnt_d = cnt_q + CntW'(push_i.row_en) + CntW'(push_i.max_en) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.row_en) begin
      ent_q[wr_q] <= row_res_i;
    end
    if (push_i.max_en) begin
      ent_q[wr_nxt] <= max_res_i;
    end
  end

endmodule

// ===== rtl/core/alternating_row_sort_column_max.sv =====
// ----------------------------------------------------------------------------
// alternating_row_sort_column_max
// Sorts rows of four signed values, ascending and descending in turn, and
// reports the column maxima after the last row of each matrix.
// ----------------------------------------------------------------------------
// A row is taken every cycle while the result queue has two free slots. A
// row is held in the input register, where the sorting network and the
// column maxima are worked out, and is then written to a four-entry
// result queue, from whose head its result can be taken. A row marked last
// adds a second result carrying the column maxima, so while the output is
// not stalled the sustained rate is one row a cycle, falling to the output
// rate of one result a cycle when last rows are frequent.
module alternating_row_sort_column_max #(
  parameter int unsigned VALUE_WIDTH = arscm_pkg::DefaultValueWidth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] elem_0_i,
  input  logic signed [15:0] elem_1_i,
  input  logic signed [15:0] elem_2_i,
  input  logic signed [15:0] elem_3_i,
  input  logic               last_row_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               kind_o,
  output logic signed [15:0] val_0_o,
  output logic signed [15:0] val_1_o,
  output logic signed [15:0] val_2_o,
  output logic signed [15:0] val_3_o,
  output logic               run_end_o
);

  localparam int unsigned N = arscm_pkg::RowLen;
  localparam int unsigned F = arscm_pkg::FieldWidth;

  logic                          accept, advance, room2;
  logic                          s1_valid_q, s1_valid_d;
  logic                          s1_last_q;
  logic signed [VALUE_WIDTH-1:0] s1_row_q [N];
  logic                          odd_q, odd_d;
  logic signed [VALUE_WIDTH-1:0] sorted   [N];
  logic signed [VALUE_WIDTH-1:0] col_max  [N];
  arscm_pkg::push_t              push;
  arscm_pkg::result_t            row_res, max_res, head;

  assign accept     = in_valid_i && !in_stall_o;
  assign advance    = s1_valid_q && room2;
  assign in_stall_o = s1_valid_q && !advance;
  assign s1_valid_d = accept || (s1_valid_q && !advance);

  always_comb begin
    odd_d = odd_q;
    if (advance) begin
      odd_d = s1_last_q ? 1'b0 : !odd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      odd_q      <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      odd_q      <= odd_d;
    end
  end

  // Fields are sign-extended, or cut, to the internal width.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_row_q[0] <= VALUE_WIDTH'(elem_0_i);
      s1_row_q[1] <= VALUE_WIDTH'(elem_1_i);
      s1_row_q[2] <= VALUE_WIDTH'(elem_2_i);
      s1_row_q[3] <= VALUE_WIDTH'(elem_3_i);
      s1_last_q   <= last_row_i;
    end
  end

  arscm_sort #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_sort (
    .row_i    (s1_row_q),
    .desc_i   (odd_q),
    .sorted_o (sorted)
  );

  arscm_colmax #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_colmax (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .upd_i  (advance),
    .last_i (s1_last_q),
    .row_i  (sorted),
    .max_o  (col_max)
  );

  always_comb begin
    row_res.kind    = arscm_pkg::KIND_ROW;
    row_res.run_end = !s1_last_q;
    max_res.kind    = arscm_pkg::KIND_MAX;
    max_res.run_end = 1'b1;
    for (int j = 0; j < N; j++) begin
      row_res.vals[j] = F'(sorted[j]);
      max_res.vals[j] = F'(col_max[j]);
    end
    push.row_en = advance;
    push.max_en = advance && s1_last_q;
  end

  arscm_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .row_res_i   (row_res),
    .max_res_i   (max_res),
    .room2_o     (room2),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .head_o      (head)
  );

  assign kind_o    = head.kind;
  assign val_0_o   = head.vals[0];
  assign val_1_o   = head.vals[1];
  assign val_2_o   = head.vals[2];
  assign val_3_o   = head.vals[3];
  assign run_end_o = head.run_end;

endmodule

// ===== rtl/core/arscm_checker.sv =====
// ----------------------------------------------------------------------------
// arscm_checker
// Port-level checks for the alternating row sorter, bound to the top level.
// ----------------------------------------------------------------------------
module arscm_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic               kind_o,
  input logic signed [15:0] val_0_o,
  input logic               run_end_o
);

  // Column maxima always close the run.
  a_max_ends_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o) |-> run_end_o)
    else $error("column maxima item without run end");

  // A row item that does not end its run is followed straight by the maxima.
  a_row_then_max : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !kind_o && !run_end_o)
      |=> (out_valid_o && kind_o))
    else $error("last row not followed by column maxima");

  // With nothing waiting at the output, the input is never held off.
  a_no_idle_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled while output queue is empty");

  // A stalled result holds.
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i)
      |=> (out_valid_o && $stable(val_0_o) && $stable(kind_o)))
    else $error("stalled output item changed");

endmodule

bind alternating_row_sort_column_max arscm_checker u_arscm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .kind_o      (kind_o),
  .val_0_o     (val_0_o),
  .run_end_o   (run_end_o)
);
